[design/mwsd_pkg.sv]
// Package for the moving-window standard deviation core.
// Holds field widths, the window length reset value and the root scaling.
// Depends on nothing.
package mwsd_pkg;

  // Field widths of the stream items and the configuration register.
  localparam int SAMPLE_W       = 16;
  localparam int DEVIATION_W    = 24;
  localparam int WLEN_W         = 9;

  // Window length after reset.
  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(20);

  // Default ring depth.
  localparam int WINDOW_MAX_DEFAULT = 256;

  // The radicand is scaled by 2^ROOT_SHIFT so the root carries 8 fraction bits.
  localparam int ROOT_SHIFT     = 16;

endpackage

[design/moving_window_stddev_core.sv]
// Top level of the moving-window population standard deviation core.
// Holds the sample ring, the running sums and the bit-serial multiply, root and divide.
// Depends on mwsd_pkg.
//
//  Channel   | Direction | Handshake                 | Payload
//  ----------+-----------+---------------------------+-----------------------------------
//  s_axis    | in        | s_axis_tvalid/tready      | tdata: sample; tuser: restart
//  m_axis    | out       | m_axis_tvalid/tready      | tdata: deviation; tuser: window_full
//  cfg       | in        | cfg_write                 | cfg_data: window_length
//
// While the window is filling, an item goes from the square and update steps straight
// to the output. With a full window it also passes through shift-and-add for N*S2 and
// S1^2, the restoring root (one radicand bit pair per cycle) and the restoring divide
// by N (one quotient bit per cycle). A new sample is taken only in the idle state.
// Reset is synchronous; it empties the window and loads the default window length.
// A finished result waits in the output register; a new sample is taken meanwhile,
// and its result is held back only while the previous one is still untaken.
module moving_window_stddev_core #(
  parameter int WINDOW_MAX = mwsd_pkg::WINDOW_MAX_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration write of window_length.
  input  logic                                cfg_write,
  input  logic [mwsd_pkg::WLEN_W-1:0]         cfg_data,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [15:0]                         s_axis_tdata,   // [15:0] sample
  input  logic                                s_axis_tuser,   // [0] restart
  // Output stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,   // [23:0] deviation
  output logic                                m_axis_tuser    // [0] window_full
);

  localparam int SW     = mwsd_pkg::SAMPLE_W;
  localparam int LW     = $clog2(WINDOW_MAX);
  localparam int NW     = $clog2(WINDOW_MAX + 1);
  localparam int CW     = (NW > mwsd_pkg::WLEN_W) ? NW : mwsd_pkg::WLEN_W;
  localparam int S1W    = SW + LW;
  localparam int S2W    = 2 * SW + LW;
  localparam int DW     = 2 * S1W;
  localparam int RP     = (DW + mwsd_pkg::ROOT_SHIFT) / 2;
  localparam int CNT_W  = $clog2(RP);

  localparam logic [CW-1:0] WMAX_C = CW'(WINDOW_MAX);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_UPDATE,
    ST_MUL,
    ST_DIFF,
    ST_ROOT,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t                      state;

  logic [mwsd_pkg::WLEN_W-1:0] window_length;
  logic [LW-1:0]               ring_write_slot;
  logic [NW-1:0]               samples_held;
  logic [S1W-1:0]              running_sum;
  logic [S2W-1:0]              running_square_sum;

  // Per-item working registers.
  logic [SW-1:0]               new_sample;
  logic [2*SW-1:0]             new_sq;
  logic [2*SW-1:0]             old_sq;
  logic [SW-1:0]               old_sample;
  logic                        replace;
  logic                        full;
  logic [CNT_W-1:0]            cnt;

  // Serial multiply registers.
  logic [DW-1:0]               acc_a;
  logic [DW-1:0]               acc_b;
  logic [DW-1:0]               mcand_a;
  logic [DW-1:0]               mcand_b;
  logic [S1W-1:0]              mplier_n;
  logic [S1W-1:0]              mplier_s;

  // Root and divide registers.
  logic [2*RP-1:0]             radicand;
  logic [RP:0]                 root_rem;
  logic [RP-1:0]               root;
  logic [NW-1:0]               div_rem;

  // Output register.
  logic [mwsd_pkg::DEVIATION_W-1:0] out_dev;
  logic                        out_full;
  logic                        out_valid;

  // Ring port.
  logic [SW-1:0]               ring [WINDOW_MAX];
  logic                        ring_we;
  logic [LW-1:0]               ring_addr;

  // Combinational helpers.
  logic [NW-1:0]               n_eff;
  logic [CW-1:0]               wl_ext;
  logic                        accept;
  logic                        empty_now;
  logic [LW-1:0]               slot_use;
  logic [NW-1:0]               held_use;
  logic [NW-1:0]               slot_inc;
  logic                        rep_now;
  logic [S1W-1:0]              sum_next;
  logic [S2W-1:0]              sq_next;
  logic [RP+2:0]               rem_sh;
  logic [RP+2:0]               trial;
  logic                        root_ge;
  logic [NW:0]                 drem_sh;
  logic                        div_ge;
  logic                        out_free;

  // Effective window length, clamped to one through WINDOW_MAX.
  always_comb begin
    wl_ext = CW'(window_length);
    if (wl_ext == '0) begin
      n_eff = NW'(1);
    end else if (wl_ext > WMAX_C) begin
      n_eff = NW'(WINDOW_MAX);
    end else begin
      n_eff = NW'(wl_ext);
    end
  end

  assign accept   = s_axis_tvalid && s_axis_tready;
  assign out_free = !out_valid || m_axis_tready;

  // Window bookkeeping seen by an incoming sample.
  always_comb begin
    empty_now = s_axis_tuser || (samples_held > n_eff) || (NW'(ring_write_slot) >= n_eff);
    slot_use  = empty_now ? '0 : ring_write_slot;
    held_use  = empty_now ? '0 : samples_held;
    rep_now   = (held_use == n_eff);
    slot_inc  = NW'(slot_use) + NW'(1);
  end

  // New running sums: drop the oldest sample when it is replaced, add the new one.
  always_comb begin
    sum_next = running_sum + S1W'(new_sample);
    sq_next  = running_square_sum + S2W'(new_sq);
    if (replace) begin
      sum_next = sum_next - S1W'(old_sample);
      sq_next  = sq_next - S2W'(old_sq);
    end
  end

  // One step of the restoring square root.
  always_comb begin
    rem_sh  = {root_rem, radicand[2*RP-1 -: 2]};
    trial   = {1'b0, root, 2'b01};
    root_ge = (rem_sh >= trial);
  end

  // One step of the restoring divide by the window length.
  always_comb begin
    drem_sh = {div_rem, root[RP-1]};
    div_ge  = (drem_sh >= {1'b0, n_eff});
  end

  // Ring access: the old sample is read in the same cycle as the new one is written.
  assign ring_we   = accept;
  assign ring_addr = slot_use;

  always_ff @(posedge clk) begin
    if (ring_we) begin
      ring[ring_addr] <= s_axis_tdata;
      old_sample      <= ring[ring_addr];
    end
  end

  assign s_axis_tready = (state == ST_IDLE);
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_dev;
  assign m_axis_tuser  = out_full;

  // Sequencer, window state and datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= ST_IDLE;
      window_length      <= mwsd_pkg::WLEN_RESET;
      ring_write_slot    <= '0;
      samples_held       <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      out_valid          <= 1'b0;
    end else begin
      if (out_valid && m_axis_tready) begin
        out_valid <= 1'b0;
      end

      // A write of the window length also empties the window.
      if (cfg_write) begin
        window_length      <= cfg_data;
        ring_write_slot    <= '0;
        samples_held       <= '0;
        running_sum        <= '0;
        running_square_sum <= '0;
      end

      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            new_sample      <= s_axis_tdata;
            new_sq          <= s_axis_tdata * s_axis_tdata;
            replace         <= rep_now;
            samples_held    <= rep_now ? held_use : held_use + NW'(1);
            ring_write_slot <= (slot_inc >= n_eff) ? '0 : LW'(slot_inc);
            if (empty_now) begin
              running_sum        <= '0;
              running_square_sum <= '0;
            end
            state <= ST_SQUARE;
          end
        end

        ST_SQUARE: begin
          old_sq <= old_sample * old_sample;
          state  <= ST_UPDATE;
        end

        ST_UPDATE: begin
          running_sum        <= sum_next;
          running_square_sum <= sq_next;
          full               <= (samples_held == n_eff);
          acc_a              <= '0;
          acc_b              <= '0;
          mcand_a            <= DW'(sq_next);
          mcand_b            <= DW'(sum_next);
          mplier_n           <= S1W'(n_eff);
          mplier_s           <= sum_next;
          root               <= '0;
          cnt                <= CNT_W'(S1W - 1);
          state              <= (samples_held == n_eff) ? ST_MUL : ST_OUT;
        end

        // Shift-and-add for N*S2 and S1*S1, one multiplier bit per cycle.
        ST_MUL: begin
          if (mplier_n[0]) begin
            acc_a <= acc_a + mcand_a;
          end
          if (mplier_s[0]) begin
            acc_b <= acc_b + mcand_b;
          end
          mcand_a  <= {mcand_a[DW-2:0], 1'b0};
          mcand_b  <= {mcand_b[DW-2:0], 1'b0};
          mplier_n <= {1'b0, mplier_n[S1W-1:1]};
          mplier_s <= {1'b0, mplier_s[S1W-1:1]};
          if (cnt == '0) begin
            state <= ST_DIFF;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end

        ST_DIFF: begin
          radicand <= (acc_a > acc_b)
                      ? {acc_a - acc_b, {mwsd_pkg::ROOT_SHIFT{1'b0}}}
                      : '0;
          root_rem <= '0;
          root     <= '0;
          div_rem  <= '0;
          cnt      <= CNT_W'(RP - 1);
          state    <= ST_ROOT;
        end

        // Restoring root, one radicand bit pair per cycle.
        ST_ROOT: begin
          radicand <= {radicand[2*RP-3:0], 2'b00};
          if (root_ge) begin
            root_rem <= (RP + 1)'(rem_sh - trial);
          end else begin
            root_rem <= (RP + 1)'(rem_sh);
          end
          root <= {root[RP-2:0], root_ge};
          if (cnt == '0) begin
            cnt   <= CNT_W'(RP - 1);
            state <= ST_DIV;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end

        // Restoring divide; quotient bits shift into the root register.
        ST_DIV: begin
          if (div_ge) begin
            div_rem <= NW'(drem_sh - {1'b0, n_eff});
          end else begin
            div_rem <= NW'(drem_sh);
          end
          root <= {root[RP-2:0], div_ge};
          if (cnt == '0) begin
            state <= ST_OUT;
          end else begin
            cnt <= cnt - CNT_W'(1);
          end
        end

        // Hand the result over once the output register is free.
        ST_OUT: begin
          if (out_free) begin
            out_dev   <= full ? root[mwsd_pkg::DEVIATION_W-1:0] : '0;
            out_full  <= full;
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
